@@ design/drt_pkg.sv @@
package drt_pkg;

    localparam int COORD_W       = 12;
    localparam int IN_COORD_W    = 13;
    localparam int AREA_W        = 2 * COORD_W;
    localparam int BOX_SCORE_W   = AREA_W + 1;
    localparam int FRAME_IDX_W   = 16;
    localparam int ENTRY_NUM_W   = 5;
    localparam int CFG_IDX_W     = 2;

    localparam int DEF_MAX_RECTS = 16;
    localparam int SCORE_BIAS    = 50;

    localparam logic [COORD_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [COORD_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_MARK   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_QUERY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_rect;

endpackage

@@ design/drt_mul.sv @@
module drt_mul (
    input  logic                          i_clk,
    input  logic [drt_pkg::COORD_W-1:0]   i_a,
    input  logic [drt_pkg::COORD_W-1:0]   i_b,
    output logic [drt_pkg::AREA_W-1:0]    o_prod
);
    import drt_pkg::*;

    logic [AREA_W-1:0] r_prod;

    // The product is registered so that its consumer starts from a flop.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ design/drt_store.sv @@
module drt_store #(
    parameter int DEPTH = drt_pkg::DEF_MAX_RECTS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  drt_pkg::t_rect       i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output drt_pkg::t_rect       o_rdata
);
    import drt_pkg::*;

    t_rect r_mem [DEPTH];
    t_rect r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/dirty_region_tracker_core.sv @@
// Dirty region tracker. Input transactions arrive on i_in_valid/o_in_ready and
// carry a kind: record a rectangle, mark the whole frame, clear with a frame
// index, or query one position of the redraw list. Only a query produces an
// output transaction, on o_out_valid/i_out_ready.
// Frame width and height are written through the configuration channel
// (i_cfg_valid/o_cfg_ready, index 0 width, index 1 height); it is always ready.
// Timing: mark and clear complete in the accepting cycle, so the next
// transaction may follow at once. A record that passes the check steps
// through bounds check, rectangle area, box update, box area and box score
// before the next acceptance, because one 12x12 multiplier is shared by
// both area products. A rejected record, or one that finds the store full,
// returns to idle after the bounds check alone.
// A query reads the rectangle store (registered read) and then registers
// its result in the output step; the next transaction is taken after that.
// The result sits in an output register: when the receiver stalls, the query
// waits in its final step until the register is free, and the block stays
// not ready meanwhile. Reset sets the full-redraw flag, zeroes the frame
// index, entry count and scores, restores 640x480, and drops o_out_valid.
// The store and bounding box hold no reset value.
module dirty_region_tracker_core #(
    parameter int MAX_RECTS = drt_pkg::DEF_MAX_RECTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_kind,
    input  logic signed [drt_pkg::IN_COORD_W-1:0] i_rect_x,
    input  logic signed [drt_pkg::IN_COORD_W-1:0] i_rect_y,
    input  logic signed [drt_pkg::IN_COORD_W-1:0] i_rect_w,
    input  logic signed [drt_pkg::IN_COORD_W-1:0] i_rect_h,
    input  logic [drt_pkg::FRAME_IDX_W-1:0]    i_frame_index,
    input  logic [drt_pkg::ENTRY_NUM_W-1:0]    i_entry_number,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [drt_pkg::COORD_W-1:0]        o_out_x,
    output logic [drt_pkg::COORD_W-1:0]        o_out_y,
    output logic [drt_pkg::COORD_W-1:0]        o_out_w,
    output logic [drt_pkg::COORD_W-1:0]        o_out_h,
    output logic                               o_whole_frame,
    output logic [drt_pkg::FRAME_IDX_W-1:0]    o_stored_index,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [drt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [drt_pkg::COORD_W-1:0]        i_cfg_data
);
    import drt_pkg::*;

    localparam int CNT_W   = $clog2(MAX_RECTS + 1);
    localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    // Each stored rectangle adds at most the bias plus a 24-bit area.
    localparam int SCORE_W = BOX_SCORE_W + CNT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_BOX  = 3'd2;
    localparam logic [2:0] S_BMUL = 3'd3;
    localparam logic [2:0] S_BSC  = 3'd4;
    localparam logic [2:0] S_QRD  = 3'd5;
    localparam logic [2:0] S_QOUT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Configuration and tracker state.
    logic [COORD_W-1:0]     r_fw;
    logic [COORD_W-1:0]     r_fh;
    logic                   r_redraw;
    logic [FRAME_IDX_W-1:0] r_last_idx;
    logic [CNT_W-1:0]       r_count;
    logic [SCORE_W-1:0]     r_score_sum;
    logic [BOX_SCORE_W-1:0] r_box_score;
    t_rect                  r_box;

    // Latched input transaction.
    logic signed [IN_COORD_W-1:0] r_in_x;
    logic signed [IN_COORD_W-1:0] r_in_y;
    logic signed [IN_COORD_W-1:0] r_in_w;
    logic signed [IN_COORD_W-1:0] r_in_h;
    logic [FRAME_IDX_W-1:0]       r_q_idx;
    logic [ENTRY_NUM_W-1:0]       r_q_num;

    // Output register.
    logic                   r_out_valid;
    logic                   r_out_found;
    t_rect                  r_out_rect;
    logic                   r_out_whole;
    logic [FRAME_IDX_W-1:0] r_out_idx;

    logic in_accept;
    logic cfg_accept;
    logic out_free;

    assign in_accept  = i_in_valid & o_in_ready;
    assign cfg_accept = i_cfg_valid & o_cfg_ready;
    assign out_free   = ~r_out_valid | i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Bounds check on the latched rectangle. With all four values known to
    // be non-negative, the low 12 bits carry the full magnitude.
    // ------------------------------------------------------------------
    t_rect             cand;
    logic [COORD_W:0]  cand_x2;
    logic [COORD_W:0]  cand_y2;
    logic              rect_bad;
    logic              store_full;

    assign cand.x = r_in_x[COORD_W-1:0];
    assign cand.y = r_in_y[COORD_W-1:0];
    assign cand.w = r_in_w[COORD_W-1:0];
    assign cand.h = r_in_h[COORD_W-1:0];
    assign cand_x2 = {1'b0, cand.x} + {1'b0, cand.w};
    assign cand_y2 = {1'b0, cand.y} + {1'b0, cand.h};

    assign rect_bad = r_in_x[IN_COORD_W-1] | r_in_y[IN_COORD_W-1] |
                      r_in_w[IN_COORD_W-1] | r_in_h[IN_COORD_W-1] |
                      (cand.x >= r_fw) | (cand.y >= r_fh) |
                      (cand_x2 > {1'b0, r_fw}) | (cand_y2 > {1'b0, r_fh});
    assign store_full = (r_count == CNT_W'(MAX_RECTS));

    // ------------------------------------------------------------------
    // Shared multiplier: rectangle area in the check step, box area in the
    // box multiply step.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] mul_a;
    logic [COORD_W-1:0] mul_b;
    logic [AREA_W-1:0]  mul_prod;

    assign mul_a = (r_state == S_CHK) ? cand.w : r_box.w;
    assign mul_b = (r_state == S_CHK) ? cand.h : r_box.h;

    drt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // ------------------------------------------------------------------
    // Bounding box growth. The first rectangle after a clear replaces the box.
    // ------------------------------------------------------------------
    logic [COORD_W:0]   box_x2;
    logic [COORD_W:0]   box_y2;
    logic [COORD_W:0]   max_x2;
    logic [COORD_W:0]   max_y2;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W:0]   grow_w;
    logic [COORD_W:0]   grow_h;
    t_rect              box_next;

    assign box_x2 = {1'b0, r_box.x} + {1'b0, r_box.w};
    assign box_y2 = {1'b0, r_box.y} + {1'b0, r_box.h};
    assign max_x2 = (box_x2 < cand_x2) ? cand_x2 : box_x2;
    assign max_y2 = (box_y2 < cand_y2) ? cand_y2 : box_y2;
    assign min_x  = (r_box.x > cand.x) ? cand.x : r_box.x;
    assign min_y  = (r_box.y > cand.y) ? cand.y : r_box.y;
    assign grow_w = max_x2 - {1'b0, min_x};
    assign grow_h = max_y2 - {1'b0, min_y};

    always_comb begin
        if (r_count == '0) begin
            box_next = cand;
        end else begin
            box_next.x = min_x;
            box_next.y = min_y;
            box_next.w = grow_w[COORD_W-1:0];
            box_next.h = grow_h[COORD_W-1:0];
        end
    end

    logic [SCORE_W-1:0] score_base;
    assign score_base = (r_count == '0) ? '0 : r_score_sum;

    // ------------------------------------------------------------------
    // Rectangle store: written in the box step, read for queries.
    // ------------------------------------------------------------------
    t_rect store_rdata;

    drt_store #(
        .DEPTH (MAX_RECTS),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_BOX),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (cand),
        .i_raddr (r_q_num[IDX_W-1:0]),
        .o_rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // Query answer, formed in the output step from the current state.
    // ------------------------------------------------------------------
    logic  q_whole;
    logic  q_use_box;
    logic  q_first;
    logic  q_found;
    t_rect q_rect;

    assign q_whole   = r_redraw | (r_last_idx != r_q_idx);
    assign q_use_box = ({{(CNT_W){1'b0}}, r_score_sum[SCORE_W-1:0]} >=
                        {{(CNT_W+SCORE_W-BOX_SCORE_W){1'b0}}, r_box_score});
    assign q_first   = (r_q_num == '0);

    always_comb begin
        q_found = 1'b0;
        q_rect  = '0;
        if (q_whole) begin
            if (q_first) begin
                q_found = 1'b1;
                q_rect.w = r_fw;
                q_rect.h = r_fh;
            end
        end else if (q_use_box) begin
            if (q_first) begin
                q_found = 1'b1;
                q_rect  = r_box;
            end
        end else if ((ENTRY_NUM_W + CNT_W)'(r_q_num) <
                     (ENTRY_NUM_W + CNT_W)'(r_count)) begin
            q_found = 1'b1;
            q_rect  = store_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_kind == KIND_RECORD) begin
                        n_state = S_CHK;
                    end else if (i_kind == KIND_QUERY) begin
                        n_state = S_QRD;
                    end
                end
            end
            S_CHK: begin
                n_state = (rect_bad | store_full) ? S_IDLE : S_BOX;
            end
            S_BOX:  n_state = S_BMUL;
            S_BMUL: n_state = S_BSC;
            S_BSC:  n_state = S_IDLE;
            S_QRD:  n_state = S_QOUT;
            S_QOUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fw        <= FRAME_WIDTH_RST;
            r_fh        <= FRAME_HEIGHT_RST;
            r_redraw    <= 1'b1;
            r_last_idx  <= '0;
            r_count     <= '0;
            r_score_sum <= '0;
            r_box_score <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_accept) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    r_fw <= i_cfg_data;
                end else if (i_cfg_index == REG_FRAME_HEIGHT) begin
                    r_fh <= i_cfg_data;
                end
            end

            if (in_accept) begin
                if (i_kind == KIND_MARK) begin
                    r_redraw <= 1'b1;
                end else if (i_kind == KIND_CLEAR) begin
                    r_last_idx <= i_frame_index;
                    r_count    <= '0;
                    r_redraw   <= 1'b0;
                end
            end

            if (r_state == S_CHK && (rect_bad | store_full)) begin
                r_redraw <= 1'b1;
            end

            // Area of the new rectangle is in the multiplier register here.
            if (r_state == S_BOX) begin
                r_count     <= r_count + 1'b1;
                r_score_sum <= score_base + SCORE_W'(SCORE_BIAS) + SCORE_W'(mul_prod);
            end

            if (r_state == S_BSC) begin
                r_box_score <= BOX_SCORE_W'(SCORE_BIAS) + BOX_SCORE_W'(mul_prod);
            end

            if (r_state == S_QOUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_x  <= i_rect_x;
            r_in_y  <= i_rect_y;
            r_in_w  <= i_rect_w;
            r_in_h  <= i_rect_h;
            r_q_idx <= i_frame_index;
            r_q_num <= i_entry_number;
        end
        if (r_state == S_BOX) begin
            r_box <= box_next;
        end
        if (r_state == S_QOUT && out_free) begin
            r_out_found <= q_found;
            r_out_rect  <= q_rect;
            r_out_whole <= r_redraw;
            r_out_idx   <= r_last_idx;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_out_x        = r_out_rect.x;
    assign o_out_y        = r_out_rect.y;
    assign o_out_w        = r_out_rect.w;
    assign o_out_h        = r_out_rect.h;
    assign o_whole_frame  = r_out_whole;
    assign o_stored_index = r_out_idx;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECTS))
        else $error("entry count exceeds store depth");

    a_clear_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_kind == KIND_CLEAR) |=> (r_count == '0 && !r_redraw))
        else $error("clear did not empty the store");

    a_reject_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && rect_bad) |=> r_redraw)
        else $error("rejected rectangle did not set the full-redraw flag");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state) == S_QOUT)
        else $error("result appeared outside the query output step");

endmodule

@@ tb/sv/tb_dirty_region_tracker_core.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the dirty region tracker. A scoreboard mirrors the
// tracker's state (stored rectangles, bounding box, scores, full-redraw flag,
// frame index) and predicts the answer for every accepted query transaction.
// A monitor compares each answer transaction, field by field, with the oldest
// pending prediction.
module tb_dirty_region_tracker_core;

    import drt_pkg::*;

    localparam int STORE_DEPTH = DEF_MAX_RECTS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int ITEM_BUDGET = 1150;

    // Indexes 2 and 3 decode to no register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [1:0]                  kind;
        logic signed [IN_COORD_W-1:0] rect_x;
        logic signed [IN_COORD_W-1:0] rect_y;
        logic signed [IN_COORD_W-1:0] rect_w;
        logic signed [IN_COORD_W-1:0] rect_h;
        logic [FRAME_IDX_W-1:0]      frame_index;
        logic [ENTRY_NUM_W-1:0]      entry_number;
    } t_tracker_cmd;

    typedef struct {
        logic                   found;
        t_rect                  area;
        logic                   whole;
        logic [FRAME_IDX_W-1:0] index;
    } t_redraw_answer;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [1:0]                    i_kind = KIND_MARK;
    logic signed [IN_COORD_W-1:0]  i_rect_x = '0;
    logic signed [IN_COORD_W-1:0]  i_rect_y = '0;
    logic signed [IN_COORD_W-1:0]  i_rect_w = '0;
    logic signed [IN_COORD_W-1:0]  i_rect_h = '0;
    logic [FRAME_IDX_W-1:0]        i_frame_index = '0;
    logic [ENTRY_NUM_W-1:0]        i_entry_number = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b1;
    logic                          o_found;
    logic [COORD_W-1:0]            o_out_x;
    logic [COORD_W-1:0]            o_out_y;
    logic [COORD_W-1:0]            o_out_w;
    logic [COORD_W-1:0]            o_out_h;
    logic                          o_whole_frame;
    logic [FRAME_IDX_W-1:0]        o_stored_index;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = REG_FRAME_WIDTH;
    logic [COORD_W-1:0]            i_cfg_data = '0;

    // Scoreboard copy of the tracker state and its two registers.
    logic [COORD_W-1:0]     cfg_width = FRAME_WIDTH_RST;
    logic [COORD_W-1:0]     cfg_height = FRAME_HEIGHT_RST;
    logic                   flag_all = 1'b1;
    logic [FRAME_IDX_W-1:0] cur_frame = '0;
    int                     n_rects = 0;
    t_rect                  rects [STORE_DEPTH];
    t_rect                  bbox = '0;
    logic                   bbox_written = 1'b0;
    logic [31:0]            score_total = '0;
    logic [31:0]            score_bbox = '0;

    t_redraw_answer pending_answers[$];

    int  errors = 0;
    int  items_sent = 0;
    int  answers_seen = 0;
    int  rects_stored = 0;
    int  overflow_hits = 0;
    int  reg_writes = 0;
    int  ready_hold = 0;
    // While steady is set neither side inserts bubbles or stalls.
    logic steady = 1'b0;

    dirty_region_tracker_core #(
        .MAX_RECTS(STORE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_rect_x       (i_rect_x),
        .i_rect_y       (i_rect_y),
        .i_rect_w       (i_rect_w),
        .i_rect_h       (i_rect_h),
        .i_frame_index  (i_frame_index),
        .i_entry_number (i_entry_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_w        (o_out_w),
        .o_out_h        (o_out_h),
        .o_whole_frame  (o_whole_frame),
        .o_stored_index (o_stored_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Scoreboard. A record is checked against the frame first; a rectangle
    // that leaves the frame, or one that finds the store full, only raises
    // the full-redraw flag. The first rectangle of a frame seeds the box and
    // both scores; later ones widen the box, add to the running score and
    // recompute the box score from the new box area.
    // ------------------------------------------------------------------
    function automatic void note_rect(input int x, input int y, input int w, input int h);
        int          fw;
        int          fh;
        int          x2;
        int          y2;
        logic [31:0] area;
        t_rect       nr;
        fw = cfg_width;
        fh = cfg_height;
        if (x < 0 || y < 0 || w < 0 || h < 0 || x >= fw || y >= fh ||
            x + w > fw || y + h > fh) begin
            flag_all = 1'b1;
            return;
        end
        if (n_rects >= STORE_DEPTH) begin
            flag_all = 1'b1;
            overflow_hits++;
            return;
        end
        nr.x = COORD_W'(x);
        nr.y = COORD_W'(y);
        nr.w = COORD_W'(w);
        nr.h = COORD_W'(h);
        area = w * h;
        if (n_rects == 0) begin
            bbox = nr;
            score_total = SCORE_BIAS + area;
            score_bbox = score_total;
        end else begin
            x2 = int'(bbox.x) + int'(bbox.w);
            y2 = int'(bbox.y) + int'(bbox.h);
            if (x2 < x + w) x2 = x + w;
            if (y2 < y + h) y2 = y + h;
            if (int'(bbox.x) > x) bbox.x = COORD_W'(x);
            if (int'(bbox.y) > y) bbox.y = COORD_W'(y);
            bbox.w = COORD_W'(x2 - int'(bbox.x));
            bbox.h = COORD_W'(y2 - int'(bbox.y));
            score_total = score_total + SCORE_BIAS + area;
            score_bbox = SCORE_BIAS + int'(bbox.w) * int'(bbox.h);
        end
        bbox_written = 1'b1;
        rects[n_rects[STORE_AW-1:0]] = nr;
        n_rects++;
        rects_stored++;
    endfunction

    // The redraw list is the whole frame when the flag is set or the frame
    // index does not match, the bounding box alone when the summed score
    // reaches the box score, and otherwise the stored rectangles in order.
    function automatic t_redraw_answer answer_for(input logic [FRAME_IDX_W-1:0] idx,
                                                  input logic [ENTRY_NUM_W-1:0] n);
        t_redraw_answer a;
        a.found = 1'b0;
        a.area = '0;
        a.whole = flag_all;
        a.index = cur_frame;
        if (flag_all || cur_frame != idx) begin
            if (n == 0) begin
                a.found = 1'b1;
                a.area.w = cfg_width;
                a.area.h = cfg_height;
            end
        end else if (score_total >= score_bbox) begin
            if (n == 0) begin
                a.found = 1'b1;
                a.area = bbox;
            end
        end else if (int'(n) < n_rects) begin
            a.found = 1'b1;
            a.area = rects[n[STORE_AW-1:0]];
        end
        return a;
    endfunction

    // True for a query that would answer with a bounding box that no record
    // has ever written; such queries are steered to a foreign frame index.
    function automatic logic reads_blank_box(input t_tracker_cmd c);
        return c.kind == KIND_QUERY && !bbox_written && !flag_all &&
               cur_frame == c.frame_index && score_total >= score_bbox;
    endfunction

    function automatic void apply_cmd(input t_tracker_cmd c);
        case (c.kind)
            KIND_RECORD: note_rect(int'(c.rect_x), int'(c.rect_y),
                                   int'(c.rect_w), int'(c.rect_h));
            KIND_MARK:   flag_all = 1'b1;
            KIND_CLEAR: begin
                cur_frame = c.frame_index;
                n_rects = 0;
                flag_all = 1'b0;
            end
            KIND_QUERY:  pending_answers.insert(pending_answers.size(),
                                                answer_for(c.frame_index, c.entry_number));
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Transaction builders. Fields a kind does not use carry random bits.
    // ------------------------------------------------------------------
    function automatic t_tracker_cmd filler(input logic [1:0] k);
        t_tracker_cmd c;
        c.kind = k;
        c.rect_x = IN_COORD_W'($urandom);
        c.rect_y = IN_COORD_W'($urandom);
        c.rect_w = IN_COORD_W'($urandom);
        c.rect_h = IN_COORD_W'($urandom);
        c.frame_index = FRAME_IDX_W'($urandom);
        c.entry_number = ENTRY_NUM_W'($urandom);
        return c;
    endfunction

    function automatic t_tracker_cmd record_cmd(input int x, input int y,
                                                input int w, input int h);
        t_tracker_cmd c;
        c = filler(KIND_RECORD);
        c.rect_x = IN_COORD_W'(x);
        c.rect_y = IN_COORD_W'(y);
        c.rect_w = IN_COORD_W'(w);
        c.rect_h = IN_COORD_W'(h);
        return c;
    endfunction

    function automatic t_tracker_cmd query_cmd(input logic [FRAME_IDX_W-1:0] idx,
                                               input logic [ENTRY_NUM_W-1:0] n);
        t_tracker_cmd c;
        c = filler(KIND_QUERY);
        c.frame_index = idx;
        c.entry_number = n;
        return c;
    endfunction

    function automatic t_tracker_cmd clear_cmd(input logic [FRAME_IDX_W-1:0] idx);
        t_tracker_cmd c;
        c = filler(KIND_CLEAR);
        c.frame_index = idx;
        return c;
    endfunction

    // A rectangle that lies inside the current frame. Sparse frames use tiny
    // rectangles so that the box grows faster than the score and the list
    // answers come out entry by entry.
    function automatic t_tracker_cmd fitting_rect(input logic sparse);
        int x;
        int y;
        int w;
        int h;
        x = $urandom_range(0, int'(cfg_width) - 1);
        y = $urandom_range(0, int'(cfg_height) - 1);
        w = $urandom_range(0, int'(cfg_width) - x);
        h = $urandom_range(0, int'(cfg_height) - y);
        if (sparse && w > 8) w = $urandom_range(0, 8);
        if (sparse && h > 8) h = $urandom_range(0, 8);
        return record_cmd(x, y, w, h);
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Input side. Every call starts and ends on a rising edge. Valid is only
    // dropped when a bubble precedes the next transaction, so back-to-back
    // transactions keep it high without a lower-then-raise in one step.
    // ------------------------------------------------------------------
    task automatic send_cmd(input t_tracker_cmd c);
        int gap;
        gap = pick_gap();
        if (reads_blank_box(c)) c.frame_index = ~cur_frame;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= c.kind;
        i_rect_x       <= c.rect_x;
        i_rect_y       <= c.rect_y;
        i_rect_w       <= c.rect_w;
        i_rect_h       <= c.rect_h;
        i_frame_index  <= c.frame_index;
        i_entry_number <= c.entry_number;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready)) @(posedge i_clk);
        apply_cmd(c);
        items_sent++;
    endtask

    // Hold the input side until every predicted answer has come back, then
    // give a record still in its sequencer steps time to retire.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [COORD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
        case (index)
            REG_FRAME_WIDTH:  cfg_width = value;
            REG_FRAME_HEIGHT: cfg_height = value;
            default: ;
        endcase
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: the receiver stalls in runs, mostly short with an
    // occasional long one, and never while steady is set.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : answer_pacing
        int r;
        if (!i_rst_n || steady) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_out_ready <= 1'b1;
                ready_hold = $urandom_range(0, 6);
            end else if (r < 93) begin
                i_out_ready <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold = $urandom_range(10, 40);
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s: got %0h, expected %0h", what, got, want));
    endtask

    // Every answer transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin : answer_check
        t_redraw_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                flag_error("answer transaction with no query outstanding");
            end else begin
                want = pending_answers.pop_front();
                check_field("found", 32'(o_found), 32'(want.found));
                check_field("out_x", 32'(o_out_x), 32'(want.area.x));
                check_field("out_y", 32'(o_out_y), 32'(want.area.y));
                check_field("out_w", 32'(o_out_w), 32'(want.area.w));
                check_field("out_h", 32'(o_out_h), 32'(want.area.h));
                check_field("whole_frame", 32'(o_whole_frame), 32'(want.whole));
                check_field("stored_index", 32'(o_stored_index), 32'(want.index));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Out of reset the flag is set, so only the whole 640x480 frame comes
    // back, at position zero, even after a good rectangle is recorded.
    task automatic test_reset_state();
        send_cmd(query_cmd(16'h0000, 5'd0));
        send_cmd(query_cmd(16'h0000, 5'd1));
        send_cmd(record_cmd(10, 10, 20, 20));
        send_cmd(query_cmd(16'h0000, 5'd0));
        send_cmd(filler(KIND_MARK));
    endtask

    task automatic check_rejected(input int x, input int y, input int w, input int h);
        send_cmd(clear_cmd(16'h0003));
        send_cmd(record_cmd(x, y, w, h));
        send_cmd(query_cmd(16'h0003, 5'd0));
    endtask

    // Each way a rectangle can miss the frame, including the signed extremes.
    task automatic test_rejected_rects();
        check_rejected(-1, 0, 1, 1);
        check_rejected(0, -4096, 1, 1);
        check_rejected(0, 0, -1, 1);
        check_rejected(0, 0, 1, -4096);
        check_rejected(640, 0, 0, 0);
        check_rejected(4095, 480, 4095, 4095);
        check_rejected(630, 0, 11, 1);
        check_rejected(0, 470, 1, 11);
    endtask

    // Box answer for a lone rectangle, list answers for two far apart, the
    // whole frame on an index mismatch and after a mark, an empty list after
    // a clear that keeps the old scores, and the box again for two
    // overlapping rectangles.
    task automatic test_redraw_lists();
        send_cmd(clear_cmd(16'hA5A5));
        send_cmd(record_cmd(0, 0, 0, 0));
        send_cmd(query_cmd(16'hA5A5, 5'd0));
        send_cmd(query_cmd(16'hA5A5, 5'd1));
        send_cmd(record_cmd(600, 400, 40, 80));
        send_cmd(query_cmd(16'hA5A5, 5'd0));
        send_cmd(query_cmd(16'hA5A5, 5'd1));
        send_cmd(query_cmd(16'hA5A5, 5'd2));
        send_cmd(query_cmd(16'hA5A5, 5'd31));
        send_cmd(query_cmd(16'h5A5A, 5'd0));
        send_cmd(filler(KIND_MARK));
        send_cmd(query_cmd(16'hA5A5, 5'd1));
        send_cmd(clear_cmd(16'hA5A5));
        send_cmd(query_cmd(16'hA5A5, 5'd0));
        send_cmd(clear_cmd(16'h0001));
        send_cmd(record_cmd(0, 0, 100, 100));
        send_cmd(record_cmd(10, 10, 100, 100));
        send_cmd(query_cmd(16'h0001, 5'd0));
        send_cmd(query_cmd(16'h0001, 5'd1));
    endtask

    // Fill all sixteen slots with separated pixels, read the last one, then
    // one more good rectangle overflows the store and forces a full redraw.
    task automatic test_store_overflow();
        int i;
        send_cmd(clear_cmd(16'h0007));
        for (i = 0; i < STORE_DEPTH; i++) send_cmd(record_cmd(i * 20, i * 20, 1, 1));
        send_cmd(query_cmd(16'h0007, ENTRY_NUM_W'(STORE_DEPTH - 1)));
        send_cmd(query_cmd(16'h0007, ENTRY_NUM_W'(STORE_DEPTH)));
        send_cmd(record_cmd(500, 300, 2, 2));
        send_cmd(query_cmd(16'h0007, 5'd0));
    endtask

    // Smallest and largest frames, and writes to indexes with no register.
    task automatic test_frame_config();
        settle();
        write_reg(REG_FRAME_WIDTH, 12'd1);
        write_reg(REG_FRAME_HEIGHT, 12'd1);
        send_cmd(clear_cmd(16'hFFFF));
        send_cmd(record_cmd(0, 0, 1, 1));
        send_cmd(query_cmd(16'hFFFF, 5'd0));
        send_cmd(record_cmd(1, 0, 0, 0));
        send_cmd(query_cmd(16'hFFFF, 5'd0));
        settle();
        write_reg(REG_FRAME_WIDTH, 12'd4095);
        write_reg(REG_FRAME_HEIGHT, 12'd4095);
        send_cmd(clear_cmd(16'h0000));
        send_cmd(record_cmd(0, 0, 4095, 4095));
        send_cmd(record_cmd(4094, 4094, 1, 1));
        send_cmd(query_cmd(16'h0000, 5'd0));
        send_cmd(query_cmd(16'h0000, 5'd1));
        send_cmd(record_cmd(4095, 0, 0, 0));
        send_cmd(query_cmd(16'h0000, 5'd0));
        settle();
        write_reg(REG_SPARE_A, 12'h005);
        write_reg(REG_SPARE_B, 12'hABC);
        send_cmd(query_cmd(16'h0001, 5'd0));
    endtask

    // One frame of traffic: usually a clear, then records (mostly inside the
    // frame) mixed with marks, early queries and stray transactions, then a
    // walk over the redraw list and a couple of arbitrary queries.
    task automatic run_frame();
        int                     i;
        int                     n_rec;
        int                     r;
        int                     last_n;
        logic                   sparse;
        logic [1:0]             k;
        logic [FRAME_IDX_W-1:0] idx;
        steady = ($urandom_range(0, 4) == 0);
        sparse = 1'($urandom_range(0, 1));
        idx = FRAME_IDX_W'($urandom);
        if ($urandom_range(0, 3) == 0) idx = cur_frame;
        if ($urandom_range(0, 7) != 0) send_cmd(clear_cmd(idx));
        n_rec = $urandom_range(0, 20);
        for (i = 0; i < n_rec; i++) begin
            r = $urandom_range(0, 99);
            k = 2'($urandom);
            if (r < 80) send_cmd(fitting_rect(sparse));
            else if (r < 88) send_cmd(filler(KIND_RECORD));
            else if (r < 91) send_cmd(filler(KIND_MARK));
            else if (r < 97) send_cmd(query_cmd(cur_frame,
                                                ENTRY_NUM_W'($urandom_range(0, n_rects + 1))));
            else send_cmd(filler(k));
        end
        last_n = (n_rects + 1 > 31) ? 31 : n_rects + 1;
        for (i = 0; i <= last_n; i++) send_cmd(query_cmd(cur_frame, ENTRY_NUM_W'(i)));
        send_cmd(query_cmd(cur_frame, ENTRY_NUM_W'($urandom)));
        send_cmd(filler(KIND_QUERY));
    endtask

    // Random traffic over a rotation of frame sizes, corners included. Each
    // size change waits for the tracker to drain first.
    task automatic test_random_traffic();
        int                 phase;
        int                 phase_end;
        logic [COORD_W-1:0] fw;
        logic [COORD_W-1:0] fh;
        phase = 0;
        while (items_sent < ITEM_BUDGET) begin
            case (phase % 6)
                0: begin fw = 12'd640;  fh = 12'd480;  end
                1: begin fw = 12'd1;    fh = 12'd1;    end
                2: begin fw = 12'd4095; fh = 12'd4095; end
                3: begin fw = 12'd1;    fh = 12'd4095; end
                4: begin fw = 12'd4095; fh = 12'd1;    end
                default: begin
                    fw = COORD_W'($urandom_range(1, 4095));
                    fh = COORD_W'($urandom_range(1, 4095));
                end
            endcase
            settle();
            write_reg(REG_FRAME_WIDTH, fw);
            write_reg(REG_FRAME_HEIGHT, fh);
            phase_end = items_sent + 190;
            while (items_sent < phase_end && items_sent < ITEM_BUDGET) run_frame();
            phase++;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_rejected_rects();
        test_redraw_lists();
        test_store_overflow();
        test_frame_config();
        test_random_traffic();
        settle();
        $display("Run covered %0d input transactions and %0d checked answers.",
                 items_sent, answers_seen);
        $display("Stored %0d rectangles, hit a full store %0d times, %0d register writes.",
                 rects_stored, overflow_hits, reg_writes);
        if (errors == 0) begin
            $display("tb_dirty_region_tracker_core: done, clean");
        end else begin
            $display("tb_dirty_region_tracker_core: done, errors");
        end
        $finish;
    end

    // Watchdog: a correct run finishes far earlier than this.
    initial begin
        #8_000_000;
        $display("Timed out with %0d answers still pending.", pending_answers.size());
        $display("tb_dirty_region_tracker_core: done, errors");
        $finish;
    end

endmodule
